// ----- hw/rtl/mihc_pkg.sv -----
`timescale 1ns / 1ps

package mihc_pkg;

    localparam int unsigned HDR_BYTES   = 32;
    localparam int unsigned ENTRY_BYTES = 24;
    localparam int unsigned COUNT_W     = 64;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned TAB_W       = 38;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [15:0] EXP_VERSION_RST = 16'd1;
    localparam logic [31:0] MAX_COUNT_RST   = 32'd1024;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_EXP_VERSION = 1'b0,
        REG_MAX_COUNT   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT_MAGIC  = 3'd1,
        ST_BAD_HEADER   = 3'd2,
        ST_BAD_TABLE    = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    // image state at the last byte, handed to the judging stage
    typedef struct packed {
        logic [COUNT_W-1:0] size;
        logic [HASH_W-1:0]  hash;
        logic               magic_ok;
        logic [15:0]        version;
        logic [15:0]        hdr_size;
        logic [31:0]        count;
        logic [31:0]        checksum;
        logic [63:0]        decl_size;
    } t_snap;

    // magic "TJM1", byte by byte
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h54;
            2'd1:    b = 8'h4A;
            2'd2:    b = 8'h4D;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// ----- hw/rtl/module_image_header_checker.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------------
// in       | in        | i_in_valid / o_in_ready   | i_image_byte, i_is_last
// out      | out       | o_out_valid / i_out_ready | o_status, o_version, o_fn_count,
//          |           |                          | o_total_size, o_checksum
// apb      | in        | i_psel, i_penable         | i_pwrite, i_paddr, i_pwdata, o_prdata
//
// one byte per cycle while the input is not stalled; the header fields and the fnv-1a step
// are updated on the transfer; the last byte's transfer latches the image state into the
// judging stage, which writes the checks into the output register once that is free
// synchronous active-low reset clears byte count, header fields and valids; hash to fnv basis
// input stalls only while judging stage and output register are full and i_out_ready is low

module module_image_header_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_image_byte,
    input  logic                   i_is_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [15:0]            o_version,
    output logic [31:0]            o_fn_count,
    output logic [63:0]            o_total_size,
    output logic [31:0]            o_checksum,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [mihc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [mihc_pkg::DATA_W-1:0] i_pwdata,
    output logic [mihc_pkg::DATA_W-1:0] o_prdata,
    output logic                   o_pready
);
    import mihc_pkg::*;

    // configuration
    logic [15:0] r_exp_version;
    logic [31:0] r_max_count;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    // running image state
    logic [COUNT_W-1:0] r_count,    n_count;
    logic [HASH_W-1:0]  r_hash,     n_hash;
    logic               r_magic_ok, n_magic_ok;
    logic [15:0]        r_version,  n_version;
    logic [15:0]        r_hdr_size, n_hdr_size;
    logic [31:0]        r_fcount,   n_fcount;
    logic [31:0]        r_cksum,    n_cksum;
    logic [63:0]        r_decl,     n_decl;
    t_snap              u_snap;

    // judging stage
    logic  r_j_valid;
    t_snap r_snap;
    logic  j_move;

    // output register
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [15:0] r_o_version;
    logic [31:0] r_o_fcount;
    logic [63:0] r_o_size;
    logic [31:0] r_o_cksum;
    logic [TAB_W-1:0] tab_end;

    logic in_acc;
    logic is_hdr;
    logic [4:0] idx;

    assign cfg_wr  = i_psel && i_penable && i_pwrite;
    assign cfg_idx = t_reg_idx'(i_paddr[2]);
    assign o_pready = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_EXP_VERSION: o_prdata = {16'd0, r_exp_version};
            REG_MAX_COUNT:   o_prdata = r_max_count;
            default:         o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= EXP_VERSION_RST;
            r_max_count   <= MAX_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_EXP_VERSION: r_exp_version <= i_pwdata[15:0];
                REG_MAX_COUNT:   r_max_count   <= i_pwdata;
                default:         r_max_count   <= r_max_count;
            endcase
        end
    end

    assign j_move     = r_j_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_j_valid || j_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_hdr     = (r_count[COUNT_W-1:5] == '0);
    assign idx        = r_count[4:0];

    // image state after this byte
    always_comb begin
        u_snap.size      = (&r_count) ? r_count : r_count + COUNT_W'(1);
        u_snap.hash      = r_hash;
        u_snap.magic_ok  = r_magic_ok;
        u_snap.version   = r_version;
        u_snap.hdr_size  = r_hdr_size;
        u_snap.count     = r_fcount;
        u_snap.checksum  = r_cksum;
        u_snap.decl_size = r_decl;
        if (is_hdr) begin
            priority if (idx < 5'd4) begin
                if (i_image_byte != magic_byte(idx[1:0])) begin
                    u_snap.magic_ok = 1'b0;
                end
            end else if (idx < 5'd6) begin
                u_snap.version[8*idx[0] +: 8] = i_image_byte;
            end else if (idx < 5'd8) begin
                u_snap.hdr_size[8*idx[0] +: 8] = i_image_byte;
            end else if (idx < 5'd12) begin
                u_snap.count[8*idx[1:0] +: 8] = i_image_byte;
            end else if (idx < 5'd16) begin
                u_snap.checksum[8*idx[1:0] +: 8] = i_image_byte;
            end else if (idx < 5'd24) begin
                u_snap.decl_size[8*idx[2:0] +: 8] = i_image_byte;
            end else begin
                u_snap.magic_ok = r_magic_ok;
            end
        end else begin
            u_snap.hash = fnv_step(r_hash, i_image_byte);
        end
    end

    always_comb begin
        n_count    = r_count;
        n_hash     = r_hash;
        n_magic_ok = r_magic_ok;
        n_version  = r_version;
        n_hdr_size = r_hdr_size;
        n_fcount   = r_fcount;
        n_cksum    = r_cksum;
        n_decl     = r_decl;
        if (in_acc) begin
            if (i_is_last) begin
                n_count    = '0;
                n_hash     = FNV_BASIS;
                n_magic_ok = 1'b1;
                n_version  = '0;
                n_hdr_size = '0;
                n_fcount   = '0;
                n_cksum    = '0;
                n_decl     = '0;
            end else begin
                n_count    = u_snap.size;
                n_hash     = u_snap.hash;
                n_magic_ok = u_snap.magic_ok;
                n_version  = u_snap.version;
                n_hdr_size = u_snap.hdr_size;
                n_fcount   = u_snap.count;
                n_cksum    = u_snap.checksum;
                n_decl     = u_snap.decl_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_hash     <= FNV_BASIS;
            r_magic_ok <= 1'b1;
            r_version  <= '0;
            r_hdr_size <= '0;
            r_fcount   <= '0;
            r_cksum    <= '0;
            r_decl     <= '0;
        end else begin
            r_count    <= n_count;
            r_hash     <= n_hash;
            r_magic_ok <= n_magic_ok;
            r_version  <= n_version;
            r_hdr_size <= n_hdr_size;
            r_fcount   <= n_fcount;
            r_cksum    <= n_cksum;
            r_decl     <= n_decl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (in_acc && i_is_last) begin
            r_j_valid <= 1'b1;
        end else if (j_move) begin
            r_j_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_is_last) begin
            r_snap <= u_snap;
        end
    end

    // end of the function table: 32 + 24 * count
    assign tab_end = (TAB_W'(r_snap.count) << 4) + (TAB_W'(r_snap.count) << 3)
                   + TAB_W'(HDR_BYTES);

    always_comb begin
        priority if (r_snap.size < COUNT_W'(HDR_BYTES) || !r_snap.magic_ok) begin
            n_status = ST_SHORT_MAGIC;
        end else if (r_snap.version != r_exp_version
                     || r_snap.hdr_size != 16'(HDR_BYTES)
                     || r_snap.decl_size != r_snap.size) begin
            n_status = ST_BAD_HEADER;
        end else if (r_snap.count == '0 || r_snap.count > r_max_count
                     || COUNT_W'(tab_end) > r_snap.size) begin
            n_status = ST_BAD_TABLE;
        end else if (r_snap.checksum != r_snap.hash) begin
            n_status = ST_BAD_CHECKSUM;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (j_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (j_move) begin
            r_status <= n_status;
            if (n_status == ST_OK) begin
                r_o_version <= r_snap.version;
                r_o_fcount  <= r_snap.count;
                r_o_size    <= r_snap.size;
                r_o_cksum   <= r_snap.checksum;
            end else begin
                r_o_version <= '0;
                r_o_fcount  <= '0;
                r_o_size    <= '0;
                r_o_cksum   <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_version    = r_o_version;
    assign o_fn_count   = r_o_fcount;
    assign o_total_size = r_o_size;
    assign o_checksum   = r_o_cksum;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_version == '0 && o_fn_count == '0 && o_total_size == '0
             && o_checksum == '0))
        else $error("failed image reports nonzero header values");

    a_ok_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |->
            (o_total_size >= 64'(HDR_BYTES) && o_fn_count != '0))
        else $error("valid image with short size or zero function count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_is_last) |=>
            (r_count == '0 && r_hash == FNV_BASIS && r_magic_ok && r_j_valid))
        else $error("image state not cleared after last transfer");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_j_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full result path");
`endif

endmodule

// ----- tb/module_image_header_checker_test.sv -----
`timescale 1ns / 1ps

module module_image_header_checker_test;
    import mihc_pkg::*;

    localparam logic [31:0] TAG_LE     = 32'h314D4A54; // "TJM1" as it sits in memory
    localparam int unsigned SETTLE     = 16;
    localparam int unsigned STALL_MAX  = 2000;
    localparam int unsigned PHASE_MIN_BYTES = 300;
    localparam int unsigned PHASE_MIN_IMGS  = 4;

    typedef enum int unsigned {
        IMG_GOOD,
        IMG_BAD_MAGIC,
        IMG_BAD_VERSION,
        IMG_BAD_HSIZE,
        IMG_BAD_DSIZE,
        IMG_COUNT_ZERO,
        IMG_COUNT_HIGH,
        IMG_COUNT_HUGE,
        IMG_BAD_SUM,
        IMG_TRUNCATED,
        IMG_NOISE
    } t_img_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_xfer;

    typedef struct packed {
        t_status     status;
        logic [15:0] version;
        logic [31:0] fn_count;
        logic [63:0] size;
        logic [31:0] stored_sum;
    } t_verdict;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  image_byte = 8'd0;
    logic        is_last    = 1'b0;
    logic        out_ready  = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr  = '0;
    logic [DATA_W-1:0] pwdata = '0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic [15:0] version;
    logic [31:0] out_fn_count;
    logic [63:0] out_total_size;
    logic [31:0] checksum;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    module_image_header_checker DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_image_byte     (image_byte),
        .i_is_last        (is_last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_version        (version),
        .o_fn_count       (out_fn_count),
        .o_total_size     (out_total_size),
        .o_checksum       (checksum),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_prdata         (prdata),
        .o_pready         (pready)
    );

    // register copies
    logic [15:0] want_version;
    logic [31:0] count_limit;

    // image state as the checker should hold it
    logic [63:0] img_len;
    logic [31:0] img_hash;
    logic        tag_ok;
    logic [15:0] hdr_version;
    logic [15:0] hdr_size;
    logic [31:0] hdr_count;
    logic [31:0] hdr_sum;
    logic [63:0] hdr_total;

    t_byte_xfer  byte_q[$];
    t_verdict    verdict_q[$];
    t_byte_xfer  next_xfer;

    bit          idle_on;
    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned stall_cycles;
    int unsigned bytes_sent;
    int unsigned queued_bytes;
    int unsigned queued_imgs;
    int unsigned verdicts_seen;
    int unsigned faults;
    int unsigned settings;
    int unsigned verdict_tally[5];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fnv1a_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] mixed;
        mixed = h ^ {24'd0, b};
        return mixed * FNV_PRIME;
    endfunction

    function automatic void clear_image();
        img_len     = '0;
        img_hash    = FNV_BASIS;
        tag_ok      = 1'b1;
        hdr_version = '0;
        hdr_size    = '0;
        hdr_count   = '0;
        hdr_sum     = '0;
        hdr_total   = '0;
    endfunction

    function automatic t_status judge_image();
        if (img_len < 64'(HDR_BYTES) || !tag_ok)
            return ST_SHORT_MAGIC;
        if (hdr_version != want_version || hdr_size != 16'(HDR_BYTES) || hdr_total != img_len)
            return ST_BAD_HEADER;
        if (hdr_count == '0 || hdr_count > count_limit ||
            64'(HDR_BYTES) + 64'(hdr_count) * 64'(ENTRY_BYTES) > img_len)
            return ST_BAD_TABLE;
        if (hdr_sum != img_hash)
            return ST_BAD_CHECKSUM;
        return ST_OK;
    endfunction

    // fold one transferred byte into the image state, queue a verdict on the last one
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        int unsigned idx;
        t_verdict    v;
        idx = int'(img_len[4:0]);
        if (img_len < 64'(HDR_BYTES)) begin
            if (idx < 4) begin
                if (b != TAG_LE[8*idx +: 8])
                    tag_ok = 1'b0;
            end else if (idx < 6) begin
                hdr_version[8*(idx-4) +: 8] = b;
            end else if (idx < 8) begin
                hdr_size[8*(idx-6) +: 8] = b;
            end else if (idx < 12) begin
                hdr_count[8*(idx-8) +: 8] = b;
            end else if (idx < 16) begin
                hdr_sum[8*(idx-12) +: 8] = b;
            end else if (idx < 24) begin
                hdr_total[8*(idx-16) +: 8] = b;
            end
        end else begin
            img_hash = fnv1a_fold(img_hash, b);
        end
        if (img_len != '1)
            img_len = img_len + 64'd1;
        if (last) begin
            v = '0;
            v.status = judge_image();
            if (v.status == ST_OK) begin
                v.version    = hdr_version;
                v.fn_count   = hdr_count;
                v.size       = img_len;
                v.stored_sum = hdr_sum;
            end
            verdict_q.push_back(v);
            clear_image();
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_q.push_back('{data: b, last: last});
        queued_bytes++;
        if (last)
            queued_imgs++;
    endtask

    task automatic queue_image(input t_img_kind kind);
        logic [7:0]   body[$];
        logic [7:0]   img[$];
        logic [255:0] hdr;
        logic [31:0]  fn_count;
        logic [31:0]  body_sum;
        int unsigned  body_len;
        int unsigned  keep;
        int unsigned  pos;
        fn_count = 32'($urandom_range(1, (count_limit < 32'd2) ? 1 : 2));
        body_len = 24 * fn_count + $urandom_range(0, 8);
        body_sum = FNV_BASIS;
        for (int i = 0; i < body_len; i++) begin
            body.push_back(8'($urandom));
            body_sum = fnv1a_fold(body_sum, body[i]);
        end
        hdr[31:0]    = TAG_LE;
        hdr[47:32]   = want_version;
        hdr[63:48]   = 16'(HDR_BYTES);
        hdr[95:64]   = fn_count;
        hdr[127:96]  = body_sum;
        hdr[191:128] = 64'(HDR_BYTES + body_len);
        hdr[223:192] = $urandom;
        hdr[255:224] = $urandom;
        pos = 0;
        unique case (kind)
            IMG_BAD_MAGIC:   pos = $urandom_range(0, 3);
            IMG_BAD_VERSION: pos = $urandom_range(4, 5);
            IMG_BAD_HSIZE:   pos = $urandom_range(6, 7);
            IMG_BAD_SUM:     pos = $urandom_range(12, 15);
            IMG_BAD_DSIZE:   pos = $urandom_range(16, 23);
            IMG_COUNT_ZERO:  hdr[95:64] = '0;
            IMG_COUNT_HIGH:  hdr[95:64] = (count_limit == '1) ? '1 : count_limit + 32'd1;
            IMG_COUNT_HUGE:  hdr[95:64] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                                     : fn_count + 32'd1;
            default: ;
        endcase
        if (kind inside {IMG_BAD_MAGIC, IMG_BAD_VERSION, IMG_BAD_HSIZE, IMG_BAD_SUM,
                         IMG_BAD_DSIZE})
            hdr[8*pos +: 8] = hdr[8*pos +: 8] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 32; i++)
            img.push_back(hdr[8*i +: 8]);
        foreach (body[i])
            img.push_back(body[i]);
        if (kind == IMG_TRUNCATED) begin
            keep = $urandom_range(1, img.size() - 1);
            while (img.size() > keep)
                void'(img.pop_back());
        end else if (kind == IMG_NOISE) begin
            img.delete();
            keep = $urandom_range(1, 40);
            for (int i = 0; i < keep; i++)
                img.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1)
                for (int i = 0; i < 4 && i < keep; i++)
                    img[i] = TAG_LE[8*i +: 8];
        end
        foreach (img[i])
            push_byte(img[i], i == img.size() - 1);
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase();
        int unsigned bytes_start;
        int unsigned imgs_start;
        int unsigned pick;
        bytes_start = queued_bytes;
        imgs_start  = queued_imgs;
        settings++;
        while (queued_bytes - bytes_start < PHASE_MIN_BYTES ||
               queued_imgs - imgs_start < PHASE_MIN_IMGS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_image(IMG_GOOD);
            else
                queue_image(t_img_kind'(1 + (pick - 50) / 5));
        end
        drain();
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_EXP_VERSION)
            want_version = val[15:0];
        else
            count_limit = val;
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_byte(image_byte, is_last);
                bytes_sent++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    next_xfer = byte_q.pop_front();
                    in_valid   <= 1'b1;
                    image_byte <= next_xfer.data;
                    is_last    <= next_xfer.last;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 6);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected result: status %0d size %h", status,
                                 out_total_size);
                end else begin
                    want = verdict_q.pop_front();
                    verdicts_seen++;
                    verdict_tally[want.status]++;
                    if (status !== want.status || version !== want.version ||
                        out_fn_count !== want.fn_count || out_total_size !== want.size ||
                        checksum !== want.stored_sum) begin
                        faults++;
                        if (faults <= 10)
                            $display({"mismatch on image %0d (exp/act): status %0d/%0d ",
                                      "version %h/%h count %h/%h size %h/%h checksum %h/%h"},
                                     verdicts_seen, want.status, status, want.version,
                                     version, want.fn_count, out_fn_count, want.size,
                                     out_total_size, want.stored_sum, checksum);
                    end
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    out_gap = $urandom_range(1, 6);
            end
        end
    end

    // watchdog: no transfer for too long while work is outstanding
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (byte_q.size() == 0 && !in_valid && verdict_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("module_image_header_checker verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        want_version = EXP_VERSION_RST;
        count_limit  = MAX_COUNT_RST;
        clear_image();
        idle_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single bytes at both extremes, partial magic, short images
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h54, 1'b1);
        push_byte(8'h54, 1'b0);
        push_byte(8'h4A, 1'b1);
        push_byte(8'h54, 1'b0);
        push_byte(8'h4A, 1'b0);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h30, 1'b1);
        push_byte(8'h54, 1'b0);
        push_byte(8'h4A, 1'b0);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h31, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        random_phase();

        reg_write(REG_EXP_VERSION, {16'($urandom), 16'h0000});
        reg_write(REG_MAX_COUNT, 32'd1);
        random_phase();

        reg_write(REG_EXP_VERSION, 32'h0000_FFFF);
        reg_write(REG_MAX_COUNT, 32'hFFFF_FFFF);
        random_phase();

        reg_write(REG_EXP_VERSION, $urandom);
        reg_write(REG_MAX_COUNT, 32'($urandom_range(2, 6)));
        random_phase();

        idle_on = 1'b0;
        reg_write(REG_EXP_VERSION, 32'd1);
        reg_write(REG_MAX_COUNT, 32'd2);
        random_phase();

        $display("%0d bytes over %0d images checked under %0d register settings",
                 bytes_sent, verdicts_seen, settings);
        $display("verdicts: %0d ok, %0d short or bad magic, %0d header, %0d table, %0d checksum",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4]);
        if (faults == 0) begin
            $display("module_image_header_checker verification clean");
        end else begin
            $display("%0d mismatches", faults);
            $display("module_image_header_checker verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mihc_pkg.sv
hw/rtl/module_image_header_checker.sv
tb/module_image_header_checker_test.sv
